@@ src/ecvs_pkg.sv @@
// Package: shared types and codes for the clock victim selector.
`timescale 1ns / 1ps
package ecvs_pkg;

  // Width of the victim slot field on the result channel.
  localparam int unsigned VIC_W = 6;
  // Width of the function code on the request channel.
  localparam int unsigned FUNC_W = 3;
  // Width of the slot index on the request channel.
  localparam int unsigned IDX_W = 6;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_INSTALL = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REF     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PIN     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_VICTIM  = 3'd4;

  // Per-slot flags held in each ring cell.
  typedef struct packed {
    logic dirty;
    logic acc;
    logic pin;
    logic valid;
  } slot_bits_t;

  // Update applied to the slot leaving the head of the ring.
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_INSTALL,
    UPD_CLEAR,
    UPD_REF,
    UPD_PIN,
    UPD_CLR_ACC
  } upd_op_e;

  typedef struct packed {
    upd_op_e op;
    logic    wr;
    logic    pin;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_OP,
    ST_LAP1,
    ST_LAP2,
    ST_FETCH,
    ST_PUSH
  } state_e;

endpackage

@@ src/ecvs_cell.sv @@
// Ring cell: holds one slot's flags and takes its neighbour's each cycle.
`timescale 1ns / 1ps
module ecvs_cell
  import ecvs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  slot_bits_t nbr_i,
  input  upd_t       upd_i,
  output slot_bits_t bits_o
);

  slot_bits_t bits_d, bits_q;

  always_comb begin
    bits_d = nbr_i;
    case (upd_i.op)
      UPD_INSTALL: begin
        bits_d = '0;
        bits_d.valid = 1'b1;
      end
      UPD_CLEAR:   bits_d = '0;
      UPD_REF: begin
        bits_d.acc   = 1'b1;
        bits_d.dirty = nbr_i.dirty | upd_i.wr;
      end
      UPD_PIN:     bits_d.pin = upd_i.pin;
      UPD_CLR_ACC: bits_d.acc = 1'b0;
      default:     bits_d = nbr_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

  assign bits_o = bits_q;

endmodule

@@ src/ecvs_seq.sv @@
// Sequencer: watches the ring head, runs the clock search, holds the result.
`timescale 1ns / 1ps
module ecvs_seq
  import ecvs_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  slot_index_i,
  input  logic              is_write_i,
  input  logic              pin_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [VIC_W-1:0]  victim_slot_o,
  output logic              victim_dirty_o,
  input  slot_bits_t        head_i,
  output upd_t              upd_o
);

  localparam int unsigned HW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [HW-1:0] LAST = HW'(SLOTS - 1);

  function automatic logic [HW-1:0] nxt(input logic [HW-1:0] p);
    nxt = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  state_e            state_d, state_q;
  state_e            dest_d, dest_q;
  logic [FUNC_W-1:0] func_d, func_q;
  logic              wr_d, wr_q;
  logic              pin_d, pin_q;
  logic [HW-1:0]     head_q;
  logic [HW-1:0]     hand_d, hand_q;
  logic [HW-1:0]     tgt_d, tgt_q;
  logic [HW-1:0]     cnt_d, cnt_q;
  logic [HW-1:0]     cand_d, cand_q;
  logic              cand_vld_d, cand_vld_q;
  logic              res_ok_d, res_ok_q;
  logic [VIC_W-1:0]  res_slot_d, res_slot_q;
  logic              res_dirty_d, res_dirty_q;
  logic              out_valid_d, out_valid_q;
  logic              out_ok_q, out_dirty_q;
  logic [VIC_W-1:0]  out_slot_q;
  logic              out_load;

  logic [HW-1:0] head_nxt;
  logic [HW-1:0] idx_w;
  logic          in_range;
  logic          elig, clean, dirty_c, lap_last;

  assign head_nxt = nxt(head_q);
  assign idx_w    = HW'(slot_index_i);
  assign in_range = (32'(slot_index_i) < SLOTS);
  assign elig     = head_i.valid & ~head_i.pin;
  assign clean    = elig & ~head_i.acc & ~head_i.dirty;
  assign dirty_c  = elig & ~head_i.acc & head_i.dirty;
  assign lap_last = (cnt_q == LAST);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    dest_d      = dest_q;
    func_d      = func_q;
    wr_d        = wr_q;
    pin_d       = pin_q;
    hand_d      = hand_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    cand_d      = cand_q;
    cand_vld_d  = cand_vld_q;
    res_ok_d    = res_ok_q;
    res_slot_d  = res_slot_q;
    res_dirty_d = res_dirty_q;
    upd_o       = '{op: UPD_NONE, wr: 1'b0, pin: 1'b0};
    out_load    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d      = func_i;
          wr_d        = is_write_i;
          pin_d       = pin_value_i;
          res_ok_d    = 1'b0;
          res_slot_d  = '0;
          res_dirty_d = 1'b0;
          case (func_i) inside
            FUNC_INSTALL, FUNC_REMOVE, FUNC_REF, FUNC_PIN: begin
              if (in_range) begin
                tgt_d   = idx_w;
                dest_d  = ST_OP;
                state_d = (head_nxt == idx_w) ? ST_OP : ST_SEEK;
              end else begin
                state_d = ST_PUSH;
              end
            end
            FUNC_VICTIM: begin
              tgt_d      = hand_q;
              dest_d     = ST_LAP1;
              cnt_d      = '0;
              cand_vld_d = 1'b0;
              state_d    = (head_nxt == hand_q) ? ST_LAP1 : ST_SEEK;
            end
            default: state_d = ST_PUSH;
          endcase
        end
      end

      // Wait for the target slot to rotate round to the head.
      ST_SEEK: begin
        if (head_nxt == tgt_q) begin
          state_d = dest_q;
        end
      end

      ST_OP: begin
        state_d = ST_PUSH;
        case (func_q)
          FUNC_INSTALL: begin
            upd_o.op = UPD_INSTALL;
            res_ok_d = 1'b1;
          end
          FUNC_REMOVE: begin
            if (head_i.valid) begin
              upd_o.op = UPD_CLEAR;
              res_ok_d = 1'b1;
            end
          end
          FUNC_REF: begin
            if (head_i.valid) begin
              upd_o.op = UPD_REF;
              upd_o.wr = wr_q;
              res_ok_d = 1'b1;
            end
          end
          FUNC_PIN: begin
            if (head_i.valid) begin
              upd_o.op  = UPD_PIN;
              upd_o.pin = pin_q;
              res_ok_d  = 1'b1;
            end
          end
          default: res_ok_d = 1'b0;
        endcase
      end

      // First lap: take a clean slot at once, clear accessed bits passed.
      ST_LAP1: begin
        cnt_d = cnt_q + 1'b1;
        if (clean) begin
          upd_o.op   = UPD_CLEAR;
          res_ok_d   = 1'b1;
          res_slot_d = VIC_W'(head_q);
          hand_d     = head_nxt;
          state_d    = ST_PUSH;
        end else begin
          if (elig) begin
            upd_o.op = UPD_CLR_ACC;
          end
          if (dirty_c && !cand_vld_q) begin
            cand_d     = head_q;
            cand_vld_d = 1'b1;
          end
          if (lap_last) begin
            cnt_d = '0;
            if (cand_vld_d) begin
              tgt_d   = cand_d;
              dest_d  = ST_FETCH;
              state_d = (head_nxt == cand_d) ? ST_FETCH : ST_SEEK;
            end else begin
              state_d = ST_LAP2;
            end
          end
        end
      end

      // Second lap: no clearing; first clean slot, else first dirty one.
      ST_LAP2: begin
        cnt_d = cnt_q + 1'b1;
        if (clean) begin
          upd_o.op   = UPD_CLEAR;
          res_ok_d   = 1'b1;
          res_slot_d = VIC_W'(head_q);
          state_d    = ST_PUSH;
        end else begin
          if (dirty_c && !cand_vld_q) begin
            cand_d     = head_q;
            cand_vld_d = 1'b1;
          end
          if (lap_last) begin
            cnt_d = '0;
            if (cand_vld_d) begin
              tgt_d   = cand_d;
              dest_d  = ST_FETCH;
              state_d = (head_nxt == cand_d) ? ST_FETCH : ST_SEEK;
            end else begin
              state_d = ST_PUSH;
            end
          end
        end
      end

      // Dirty candidate is at the head: evict it.
      ST_FETCH: begin
        upd_o.op    = UPD_CLEAR;
        res_ok_d    = 1'b1;
        res_slot_d  = VIC_W'(head_q);
        res_dirty_d = head_i.dirty;
        state_d     = ST_PUSH;
      end

      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dest_q      <= ST_OP;
      head_q      <= '0;
      hand_q      <= '0;
      cnt_q       <= '0;
      cand_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dest_q      <= dest_d;
      head_q      <= head_nxt;
      hand_q      <= hand_d;
      cnt_q       <= cnt_d;
      cand_vld_q  <= cand_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    wr_q        <= wr_d;
    pin_q       <= pin_d;
    tgt_q       <= tgt_d;
    cand_q      <= cand_d;
    res_ok_q    <= res_ok_d;
    res_slot_q  <= res_slot_d;
    res_dirty_q <= res_dirty_d;
    if (out_load) begin
      out_ok_q    <= res_ok_q;
      out_slot_q  <= res_slot_q;
      out_dirty_q <= res_dirty_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign victim_slot_o  = out_slot_q;
  assign victim_dirty_o = out_dirty_q;

endmodule

@@ src/enhanced_clock_victim_select_core.sv @@
// Top level: enhanced second-chance clock victim selector over a ring of slot cells.
//
// Request channel (in_valid_i / in_ready_o): func_i picks install, remove,
// reference, set pin or find victim; slot_index_i, is_write_i and
// pin_value_i qualify it. Every request gives exactly one result on the
// result channel (out_valid_o / out_ready_i): ok_o, victim_slot_o and
// victim_dirty_o.
// The slot table lives in a ring of SLOTS cells that rotates one place
// every cycle; only the cell at the head is inspected or updated.
// Steps: install, remove, reference and pin wait for their slot to reach
// the head, then act and give the result. A victim search waits for the
// hand slot, walks one lap of the ring and may walk a second; a dirty
// candidate from either lap must come round to the head again before it
// is evicted and the result given. Bad slot indices and unused codes go
// straight to the result.
// One request is in progress at a time; a finished result sits in the
// output register, so the next request is taken while it waits. If the
// receiver stalls with the output register full, the next finished
// result holds internally and no new request is taken.
// Reset clears every cell (all slots invalid), the hand and the ring
// position at once; no clearing pass is needed.
`timescale 1ns / 1ps
module enhanced_clock_victim_select_core
  import ecvs_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [IDX_W-1:0]  slot_index_i,
  input  logic              is_write_i,
  input  logic              pin_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [VIC_W-1:0]  victim_slot_o,
  output logic              victim_dirty_o
);

  // ring[0] is the head; cell i takes cell i+1 each cycle, and the last
  // cell takes the head's flags after the sequencer's update.
  slot_bits_t ring [SLOTS];
  upd_t       head_upd;
  upd_t       idle_upd;

  // Cells away from the tail only shift.
  assign idle_upd = '{op: UPD_NONE, wr: 1'b0, pin: 1'b0};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      ecvs_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .nbr_i  (ring[0]),
        .upd_i  (head_upd),
        .bits_o (ring[i])
      );
    end else begin : g_body
      ecvs_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .nbr_i  (ring[i+1]),
        .upd_i  (idle_upd),
        .bits_o (ring[i])
      );
    end
  end

  ecvs_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .slot_index_i   (slot_index_i),
    .is_write_i     (is_write_i),
    .pin_value_i    (pin_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .victim_slot_o  (victim_slot_o),
    .victim_dirty_o (victim_dirty_o),
    .head_i         (ring[0]),
    .upd_o          (head_upd)
  );

endmodule

@@ src/ecvs_checker.sv @@
// Port checker for the clock victim selector, bound to the top level.
`timescale 1ns / 1ps
module ecvs_checker
  import ecvs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              ok_o,
  input logic [VIC_W-1:0]  victim_slot_o,
  input logic              victim_dirty_o
);

  // A taken request keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one still in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o)
      && $stable(victim_slot_o) && $stable(victim_dirty_o))
    else $error("result changed while stalled");

  // A failed request reports no victim.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> victim_slot_o == '0 && !victim_dirty_o)
    else $error("failed result carries victim fields");

  // A write-back flag only comes with a successful search.
  a_dirty_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && victim_dirty_o |-> ok_o)
    else $error("dirty victim without success");

endmodule

bind enhanced_clock_victim_select_core ecvs_checker u_ecvs_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the enhanced second-chance clock victim selector.
`timescale 1ns / 1ps
module testbench;
  import ecvs_pkg::*;

  // The block is built at its default table size; the shadow copy matches it.
  localparam int unsigned SLOTS = 64;
  // Function codes that the block must answer with ok = 0 and no side effect.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;
  // The watchdog limit exceeds the long receiver hold-off plus the longest search.
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS + 16;

  // One result as the block should give it.
  typedef struct packed {
    logic             ok;
    logic [VIC_W-1:0] slot;
    logic             dirty;
  } outcome_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i         = FUNC_INSTALL;
  logic [IDX_W-1:0]  slot_index_i   = '0;
  logic              is_write_i     = 1'b0;
  logic              pin_value_i    = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic              ok_o;
  logic [VIC_W-1:0]  victim_slot_o;
  logic              victim_dirty_o;

  // Shadow of the slot table and clock hand, kept in request order.
  slot_bits_t  shadow_slots [SLOTS];
  int unsigned shadow_hand;
  outcome_t    expected_results [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic        no_idle        = 1'b0;  // both sides stop idling while set
  logic        hold_active    = 1'b0;  // long receiver hold-off in progress
  event        hold_go;

  enhanced_clock_victim_select_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .slot_index_i  (slot_index_i),
    .is_write_i    (is_write_i),
    .pin_value_i   (pin_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .victim_slot_o (victim_slot_o),
    .victim_dirty_o(victim_dirty_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic evictable(int unsigned p);
    return shadow_slots[p].valid && !shadow_slots[p].pin;
  endfunction

  function automatic int unsigned step_hand(int unsigned p);
    return (p + 1 >= SLOTS) ? 0 : p + 1;
  endfunction

  // Enhanced clock sweep; returns SLOTS when nothing can be evicted.
  function automatic int unsigned clock_sweep();
    int unsigned start;
    int unsigned cand;
    int unsigned p;
    int unsigned i;
    start = shadow_hand;
    cand  = SLOTS;
    p     = start;
    // First lap: a clean, unreferenced slot is taken at once and moves the
    // hand; referenced bits are cleared as the hand passes.
    for (i = 0; i < SLOTS; i++) begin
      if (evictable(p)) begin
        if (!shadow_slots[p].acc && !shadow_slots[p].dirty) begin
          shadow_hand = step_hand(p);
          return p;
        end
        if (!shadow_slots[p].acc && cand == SLOTS) cand = p;
        shadow_slots[p].acc = 1'b0;
      end
      p = step_hand(p);
    end
    // A dirty candidate from the first lap wins; the hand stays put.
    if (cand != SLOTS) return cand;
    // Second lap without clearing; the hand stays put.
    p = start;
    for (i = 0; i < SLOTS; i++) begin
      if (evictable(p)) begin
        if (!shadow_slots[p].acc && !shadow_slots[p].dirty) return p;
        if (!shadow_slots[p].acc && cand == SLOTS) cand = p;
      end
      p = step_hand(p);
    end
    return cand;
  endfunction

  function automatic outcome_t predict_outcome(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                                               logic wr, logic pin);
    outcome_t    res;
    logic        in_range;
    logic        live;
    int unsigned v;
    res      = '0;
    in_range = (int'(idx) < SLOTS);
    live     = in_range && shadow_slots[in_range ? idx : 0].valid;
    case (f)
      FUNC_INSTALL: begin
        if (in_range) begin
          shadow_slots[idx]       = '0;
          shadow_slots[idx].valid = 1'b1;
          res.ok                  = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (live) begin
          shadow_slots[idx] = '0;
          res.ok            = 1'b1;
        end
      end
      FUNC_REF: begin
        if (live) begin
          shadow_slots[idx].acc = 1'b1;
          if (wr) shadow_slots[idx].dirty = 1'b1;
          res.ok = 1'b1;
        end
      end
      FUNC_PIN: begin
        if (live) begin
          shadow_slots[idx].pin = pin;
          res.ok                = 1'b1;
        end
      end
      FUNC_VICTIM: begin
        v = clock_sweep();
        if (v < SLOTS) begin
          res.ok    = 1'b1;
          res.slot  = v[VIC_W-1:0];
          res.dirty = shadow_slots[v].dirty;
          shadow_slots[v] = '0;
        end
      end
      default: begin
        // unused codes: no change, ok stays 0
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offers one request after a random gap and records its expected result
  // at the edge where it is taken. Valid is only lowered when a gap
  // follows, so back-to-back requests never see two updates in one step.
  task automatic send_request(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                              logic wr, logic pin);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    slot_index_i <= idx;
    is_write_i   <= wr;
    pin_value_i  <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_outcome(f, idx, wr, pin));
  endtask

  // Sender stops and waits for every outstanding result.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Mostly a slot that is live in the shadow table, so references, pins
  // and removals reach real state; sometimes any slot at all.
  function automatic logic [IDX_W-1:0] pick_slot();
    int unsigned live_slots [$];
    for (int unsigned p = 0; p < SLOTS; p++) begin
      if (shadow_slots[p].valid) live_slots.push_back(p);
    end
    if (live_slots.size() != 0 && $urandom_range(0, 99) < 85)
      return IDX_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
    return IDX_W'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic random_request();
    int unsigned      roll;
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  idx;
    logic              wr;
    logic              pin;
    roll = $urandom_range(0, 99);
    idx  = pick_slot();
    wr   = 1'($urandom_range(0, 1));
    pin  = ($urandom_range(0, 99) < 30);
    if (roll < 5) begin
      f   = FUNC_W'($urandom_range(FUNC_UNUSED_5, FUNC_UNUSED_7));
      idx = IDX_W'($urandom_range(0, SLOTS - 1));
    end else if (roll < 35) begin
      f   = FUNC_INSTALL;
      idx = IDX_W'($urandom_range(0, SLOTS - 1));
    end else if (roll < 57) begin
      f = FUNC_REF;
    end else if (roll < 65) begin
      f = FUNC_PIN;
    end else if (roll < 72) begin
      f = FUNC_REMOVE;
    end else begin
      f = FUNC_VICTIM;
    end
    send_request(f, idx, wr, pin);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked corner cases: empty and fully pinned tables, requests on
  // dead slots, both search laps, the dirty candidate, hand wrap, unused
  // codes and the slot index extremes.
  task automatic test_directed();
    send_request(FUNC_VICTIM,  6'd0,  1'b0, 1'b0);  // empty table: no victim
    send_request(FUNC_REMOVE,  6'd5,  1'b0, 1'b0);  // dead slot
    send_request(FUNC_REF,     6'd5,  1'b1, 1'b0);
    send_request(FUNC_PIN,     6'd5,  1'b0, 1'b1);
    send_request(FUNC_INSTALL, 6'd0,  1'b0, 1'b0);
    send_request(FUNC_INSTALL, 6'd63, 1'b1, 1'b1);
    send_request(FUNC_PIN,     6'd0,  1'b0, 1'b1);
    send_request(FUNC_PIN,     6'd63, 1'b0, 1'b1);
    send_request(FUNC_VICTIM,  6'd0,  1'b0, 1'b0);  // all pinned: no victim
    send_request(FUNC_PIN,     6'd0,  1'b1, 1'b0);
    send_request(FUNC_REF,     6'd0,  1'b1, 1'b0);  // write: accessed + dirty
    send_request(FUNC_INSTALL, 6'd30, 1'b0, 1'b0);
    send_request(FUNC_REF,     6'd30, 1'b0, 1'b1);  // read only
    send_request(FUNC_VICTIM,  6'd0,  1'b0, 1'b0);  // second lap finds 30 clean
    send_request(FUNC_VICTIM,  6'd0,  1'b0, 1'b0);  // dirty candidate from lap one
    send_request(FUNC_PIN,     6'd63, 1'b0, 1'b0);
    send_request(FUNC_VICTIM,  6'd0,  1'b0, 1'b0);  // takes 63, hand wraps to 0
    send_request(FUNC_UNUSED_5, 6'd63, 1'b1, 1'b1);
    send_request(FUNC_UNUSED_6, 6'd0,  1'b0, 1'b1);
    send_request(FUNC_UNUSED_7, 6'd31, 1'b1, 1'b0);
    send_request(FUNC_INSTALL, 6'd63, 1'b0, 1'b0);
    send_request(FUNC_REMOVE,  6'd63, 1'b0, 1'b0);
    send_request(FUNC_REMOVE,  6'd63, 1'b0, 1'b0);  // already gone
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) random_request();
  endtask

  // Neither side idles: requests and results back to back.
  task automatic test_no_idle(int unsigned n);
    no_idle = 1'b1;
    repeat (n) random_request();
    no_idle = 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so
  // the block fills and stalls its input; then the sender drains.
  task automatic test_backpressure(int unsigned n);
    -> hold_go;
    repeat (n) random_request();
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------
  // Result side: stall drawing and checking
  // ---------------------------------------------------------------------

  initial begin : hold_off
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  initial begin : result_checker
    int unsigned stall_left;
    outcome_t    want;
    stall_left = $urandom_range(0, 11);
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request outstanding: ok=%0b slot=%0d dirty=%0b",
                   $time, ok_o, victim_slot_o, victim_dirty_o);
        end else begin
          want = expected_results.pop_front();
          if (ok_o !== want.ok) begin
            mismatch_count++;
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok_o);
          end
          if (victim_slot_o !== want.slot) begin
            mismatch_count++;
            $display("%0t: victim_slot expected %0d actual %0d",
                     $time, want.slot, victim_slot_o);
          end
          if (victim_dirty_o !== want.dirty) begin
            mismatch_count++;
            $display("%0t: victim_dirty expected %0b actual %0b",
                     $time, want.dirty, victim_dirty_o);
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (hold_active) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0 && !no_idle) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin : run_tests
    for (int unsigned p = 0; p < SLOTS; p++) shadow_slots[p] = '0;
    shadow_hand = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(200);
    test_backpressure(30);
    test_no_idle(50);
    test_random(250);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
